### sv/mono_bitmap_display_cursor_overlay_core_defines.svh
// assertion macros used by the bound checker file
`ifndef MONO_BITMAP_DISPLAY_CURSOR_OVERLAY_CORE_DEFINES_SVH
`define MONO_BITMAP_DISPLAY_CURSOR_OVERLAY_CORE_DEFINES_SVH

// property checked only while out of reset
`define MBDC_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define MBDC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/mbdc_pkg.sv
// shared constants, types and color helper for the bitmap display core
`default_nettype none

package mbdc_pkg;

    localparam int DISPLAY_LINES = 808;
    localparam int LINE_PIXELS   = 606;
    localparam int LINE_WORDS    = 38;
    localparam int CURSOR_SIZE   = 16;

    localparam logic [31:0] BACKGROUND_ARGB = 32'hFF050403;
    localparam logic [31:0] ALPHA_OPAQUE    = 32'hFF000000;

    typedef enum logic [2:0] {
        REG_PHOSPHOR_COLOR = 3'd0,
        REG_CURSOR_COLOR   = 3'd1,
        REG_CURSOR_COL     = 3'd2,
        REG_CURSOR_ROW     = 3'd3,
        REG_ORIGIN_X       = 3'd4,
        REG_ORIGIN_Y       = 3'd5,
        REG_WINDOW_WIDTH   = 3'd6,
        REG_WINDOW_HEIGHT  = 3'd7
    } t_cfg_reg;

    typedef enum logic {
        ACT_DISPLAY     = 1'b0,
        ACT_CURSOR_LOAD = 1'b1
    } t_action;

    // per-word job handed to the pixel emitter, bit i is pixel i from the left
    typedef struct packed {
        logic [15:0] lit;
        logic [15:0] cur;
        logic [31:0] lit_argb;
        logic [31:0] over_argb;
        logic [11:0] dx0;
        logic [11:0] dy;
    } t_word_job;

    // 3/4 of each color channel, truncating, alpha opaque
    function automatic logic [31:0] dim_color(input logic [31:0] c);
        logic [9:0] r3;
        logic [9:0] g3;
        logic [9:0] b3;
        r3 = {2'b00, c[23:16]} + {1'b0, c[23:16], 1'b0};
        g3 = {2'b00, c[15:8]}  + {1'b0, c[15:8], 1'b0};
        b3 = {2'b00, c[7:0]}   + {1'b0, c[7:0], 1'b0};
        return ALPHA_OPAQUE | {8'h00, r3[9:2], g3[9:2], b3[9:2]};
    endfunction

endpackage

`default_nettype wire

### sv/mbdc_emitter.sv
// serializes one word job into pixels, one per cycle while the output is not stalled, through an output register
`default_nettype none

module mbdc_emitter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_job_valid,
    input  wire logic [15:0]        i_emit_mask,
    input  wire mbdc_pkg::t_word_job i_job,
    output logic                    o_job_ready,
    output logic                    o_pix_valid,
    input  wire logic               i_pix_ready,
    output logic [55:0]             o_pix_data,   // pixel_color, dest_x, dest_y
    output logic                    o_pix_last
);

    mbdc_pkg::t_word_job r_job;
    logic [15:0]         r_pending;
    logic                r_out_valid;
    logic [31:0]         r_out_color;
    logic [11:0]         r_out_dx;
    logic [11:0]         r_out_dy;
    logic                r_out_last;

    logic        pick_found;
    logic [3:0]  pick_idx;
    logic        out_free;
    logic        out_load;
    logic [15:0] n_pending;
    logic [31:0] pick_color;

    // leftmost pending pixel
    always_comb begin
        pick_found = 1'b0;
        pick_idx   = 4'd0;
        for (int i = 15; i >= 0; i--) begin
            if (r_pending[i]) begin
                pick_found = 1'b1;
                pick_idx   = 4'(i);
            end
        end
    end

    assign out_free    = !r_out_valid || i_pix_ready;
    assign out_load    = pick_found && out_free;
    assign n_pending   = out_load ? (r_pending & ~(16'h0001 << pick_idx)) : r_pending;
    assign o_job_ready = (n_pending == 16'h0000);

    always_comb begin
        if (r_job.cur[pick_idx]) begin
            pick_color = r_job.over_argb;
        end else if (r_job.lit[pick_idx]) begin
            pick_color = r_job.lit_argb;
        end else begin
            pick_color = mbdc_pkg::BACKGROUND_ARGB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 16'h0000;
            r_out_valid <= 1'b0;
        end else begin
            if (i_job_valid && o_job_ready) begin
                r_pending <= i_emit_mask;
            end else begin
                r_pending <= n_pending;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pix_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_valid && o_job_ready) begin
            r_job <= i_job;
        end
        if (out_load) begin
            r_out_color <= pick_color;
            r_out_dx    <= r_job.dx0 + {8'h00, pick_idx};
            r_out_dy    <= r_job.dy;
            r_out_last  <= (n_pending == 16'h0000);
        end
    end

    assign o_pix_valid = r_out_valid;
    assign o_pix_data  = {r_out_dy, r_out_dx, r_out_color};
    assign o_pix_last  = r_out_last;

endmodule

`default_nettype wire

### sv/mono_bitmap_display_cursor_overlay_core.sv
// Monochrome bitmap display core with cursor overlay: display words (tuser low) arrive in
// raster order, 38 per line and 808 lines per frame, and each becomes up to sixteen ARGB
// pixels, leftmost first, with tlast on the last pixel of the word; words whose pixels all
// fall outside the line or the destination window give no output. Items with tuser high load
// one row of the 16x16 cursor bitmap and give no output. An item is registered on entry,
// turned into per-pixel masks in one pass, then handed to an emitter that drives one pixel per
// cycle, while the output is not stalled, into the output register; a display word holds the
// emitter until its last visible pixel is loaded. A first pixel passes the input register, the
// emitter's pending mask and the output register. The single pixel output port sets the rate.
// Configuration must be written only while idle; the block itself does not enforce this.
`default_nettype none

module mono_bitmap_display_cursor_overlay_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // row_select[3:0], data_word[19:4], zero pad
    input  wire logic        s_axis_tuser,   // action
    // pixel stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // pixel_color[31:0], dest_x[43:32], dest_y[55:44]
    output logic             m_axis_tlast
);

    // configuration registers
    logic [31:0]        r_phosphor_color;
    logic [31:0]        r_cursor_argb;
    logic [9:0]         r_cursor_col;
    logic [9:0]         r_cursor_row;
    logic [11:0]        r_origin_x;
    logic [11:0]        r_origin_y;
    logic [12:0]        r_window_width;
    logic [12:0]        r_window_height;

    // raster position
    logic [9:0]         r_line_count;
    logic [5:0]         r_word_count;

    logic [15:0]        r_cursor_store [mbdc_pkg::CURSOR_SIZE];

    // input register
    logic               r_s1_valid;
    mbdc_pkg::t_action  r_s1_action;
    logic [3:0]         r_s1_sel;
    logic [15:0]        r_s1_word;
    logic [9:0]         r_s1_line;
    logic [5:0]         r_s1_wcnt;

    logic               in_accept;
    logic               s1_move;
    logic               job_ready;
    logic               job_valid;
    mbdc_pkg::t_action  in_action;

    logic [9:0]         x_base;
    logic [13:0]        dy_full;
    logic               line_ok;
    logic               cur_line;
    logic [3:0]         cur_y;
    logic [15:0]        cur_bits;
    logic [15:0]        emit_mask;
    mbdc_pkg::t_word_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phosphor_color <= 32'hFFFFFFFF;
            r_cursor_argb    <= 32'hFFFFFFFF;
            r_cursor_col     <= 10'd0;
            r_cursor_row     <= 10'd0;
            r_origin_x       <= 12'd0;
            r_origin_y       <= 12'd0;
            r_window_width   <= 13'd1024;
            r_window_height  <= 13'd1024;
        end else if (i_cfg_wr_en) begin
            unique case (mbdc_pkg::t_cfg_reg'(i_cfg_index))
                mbdc_pkg::REG_PHOSPHOR_COLOR: r_phosphor_color <= i_cfg_data;
                mbdc_pkg::REG_CURSOR_COLOR:   r_cursor_argb    <= i_cfg_data;
                mbdc_pkg::REG_CURSOR_COL:     r_cursor_col     <= i_cfg_data[9:0];
                mbdc_pkg::REG_CURSOR_ROW:     r_cursor_row     <= i_cfg_data[9:0];
                mbdc_pkg::REG_ORIGIN_X:       r_origin_x       <= i_cfg_data[11:0];
                mbdc_pkg::REG_ORIGIN_Y:       r_origin_y       <= i_cfg_data[11:0];
                mbdc_pkg::REG_WINDOW_WIDTH:   r_window_width   <= i_cfg_data[12:0];
                mbdc_pkg::REG_WINDOW_HEIGHT:  r_window_height  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign in_action     = mbdc_pkg::t_action'(s_axis_tuser);
    assign s1_move       = r_s1_valid &&
                           (r_s1_action == mbdc_pkg::ACT_CURSOR_LOAD || job_ready);
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign job_valid     = r_s1_valid && (r_s1_action == mbdc_pkg::ACT_DISPLAY);

    // position advances as each display word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count <= 10'd0;
            r_word_count <= 6'd0;
            r_s1_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (in_accept && in_action == mbdc_pkg::ACT_DISPLAY) begin
                if (r_word_count == 6'(mbdc_pkg::LINE_WORDS - 1)) begin
                    r_word_count <= 6'd0;
                    if (r_line_count == 10'(mbdc_pkg::DISPLAY_LINES - 1)) begin
                        r_line_count <= 10'd0;
                    end else begin
                        r_line_count <= r_line_count + 10'd1;
                    end
                end else begin
                    r_word_count <= r_word_count + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_action <= in_action;
            r_s1_sel    <= s_axis_tdata[3:0];
            r_s1_word   <= s_axis_tdata[19:4];
            r_s1_line   <= r_line_count;
            r_s1_wcnt   <= r_word_count;
        end
    end

    // cursor rows are written in stream order, after earlier words took their masks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mbdc_pkg::CURSOR_SIZE; i++) begin
                r_cursor_store[i] <= 16'h0000;
            end
        end else if (s1_move && r_s1_action == mbdc_pkg::ACT_CURSOR_LOAD) begin
            r_cursor_store[r_s1_sel] <= r_s1_word;
        end
    end

    assign x_base   = {r_s1_wcnt, 4'b0000};
    assign dy_full  = {{2{r_origin_y[11]}}, r_origin_y} + {4'b0000, r_s1_line};
    assign line_ok  = !dy_full[13] && (dy_full[12:0] < r_window_height);
    assign cur_line = ({1'b0, r_s1_line} >= {1'b0, r_cursor_row}) &&
                      ({1'b0, r_s1_line} < ({1'b0, r_cursor_row} + 11'd16));
    assign cur_y    = r_s1_line[3:0] - r_cursor_row[3:0];
    assign cur_bits = r_cursor_store[cur_y];

    always_comb begin
        logic [10:0] x_i;
        logic [13:0] dx_i;
        logic [3:0]  cx;
        logic        in_cur_col;
        emit_mask = 16'h0000;
        job.cur   = 16'h0000;
        job.lit   = 16'h0000;
        for (int i = 0; i < 16; i++) begin
            x_i  = {1'b0, x_base} + 11'(i);
            dx_i = {{2{r_origin_x[11]}}, r_origin_x} + {3'b000, x_i};
            cx   = x_i[3:0] - r_cursor_col[3:0];
            in_cur_col = (x_i >= {1'b0, r_cursor_col}) &&
                         (x_i < ({1'b0, r_cursor_col} + 11'd16));
            emit_mask[i] = line_ok && (x_i < 11'(mbdc_pkg::LINE_PIXELS)) &&
                           !dx_i[13] && (dx_i[12:0] < r_window_width);
            job.lit[i]   = r_s1_word[15 - i];
            job.cur[i]   = cur_line && in_cur_col && cur_bits[4'd15 - cx];
        end
        job.lit_argb     = r_s1_line[0] ? r_phosphor_color
                                        : mbdc_pkg::dim_color(r_phosphor_color);
        job.over_argb    = r_cursor_argb;
        job.dx0          = r_origin_x + {2'b00, x_base};
        job.dy           = dy_full[11:0];
    end

    mbdc_emitter u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_emit_mask (emit_mask),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_pix_valid (m_axis_tvalid),
        .i_pix_ready (m_axis_tready),
        .o_pix_data  (m_axis_tdata),
        .o_pix_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### sv/mbdc_checker.sv
// port-level checks on the pixel stream, bound to the core
`default_nettype none

`include "mono_bitmap_display_cursor_overlay_core_defines.svh"

module mbdc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // stalled pixel holds
    `MBDC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "pixel changed while stalled")

    // reset empties the output register
    `MBDC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "pixel valid after reset")

    // pixels of one word follow back to back on the same line
    `MBDC_ASSERT_RST(a_word_burst, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tdata[55:44] == $past(m_axis_tdata[55:44]), "word burst broken")

    // within a word the column never repeats from one pixel to the next
    `MBDC_ASSERT_RST(a_word_column, i_clk, i_rst_n, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tdata[43:32] != $past(m_axis_tdata[43:32]), "column repeated in word")

endmodule

bind mono_bitmap_display_cursor_overlay_core mbdc_checker u_mbdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### verif/mbdc_pixel_checker.sv
// pixel stream checker: tracks config and raster position, predicts pixels, compares them
`timescale 1ns / 1ps

module mbdc_pixel_checker
    import mbdc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // row_select[3:0], data_word[19:4], zero pad
    input  wire logic        s_axis_tuser,   // action
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [55:0] m_axis_tdata,   // pixel_color[31:0], dest_x[43:32], dest_y[55:44]
    input  wire logic        m_axis_tlast,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int WORD_BITS = 16;

    typedef struct packed {
        logic [31:0] argb;
        logic [11:0] x;
        logic [11:0] y;
        logic        end_of_word;
    } t_pixel;

    t_pixel      pending_pixels[$];

    logic [31:0] phosphor_argb;
    logic [31:0] cursor_argb;
    int          cursor_left;
    int          cursor_top;
    int          shift_x;
    int          shift_y;
    int          win_w;
    int          win_h;

    int          src_line;
    int          src_word;
    logic [15:0] cursor_rows[CURSOR_SIZE];

    function automatic logic [31:0] three_quarter(input logic [31:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = 8'((int'(c[23:16]) * 3) / 4);
        g = 8'((int'(c[15:8]) * 3) / 4);
        b = 8'((int'(c[7:0]) * 3) / 4);
        return ALPHA_OPAQUE | {8'h00, r, g, b};
    endfunction

    // expands one display word into its visible pixels, then steps the raster position
    task automatic render_word(input logic [15:0] bits);
        int          dy;
        int          x;
        int          dx;
        logic [31:0] lit_argb;
        logic        cursor_line;
        logic [3:0]  cy;
        logic [3:0]  cx;
        t_pixel      px;
        logic        have_px;
        have_px = 1'b0;
        px = '0;
        dy = shift_y + src_line;
        lit_argb = (src_line % 2 == 0) ? three_quarter(phosphor_argb) : phosphor_argb;
        cursor_line = src_line >= cursor_top && src_line < cursor_top + CURSOR_SIZE;
        if (dy >= 0 && dy < win_h) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                x = src_word * WORD_BITS + i;
                dx = shift_x + x;
                if (x < LINE_PIXELS && dx >= 0 && dx < win_w) begin
                    // hold one back so the final pixel of the word can carry the flag
                    if (have_px) begin
                        pending_pixels.push_back(px);
                    end
                    px.argb = bits[15 - i] ? lit_argb : BACKGROUND_ARGB;
                    if (cursor_line && x >= cursor_left && x < cursor_left + CURSOR_SIZE) begin
                        cy = 4'(src_line - cursor_top);
                        cx = 4'(x - cursor_left);
                        if (cursor_rows[cy][15 - cx]) begin
                            px.argb = cursor_argb;
                        end
                    end
                    px.x = 12'(dx);
                    px.y = 12'(dy);
                    px.end_of_word = 1'b0;
                    have_px = 1'b1;
                end
            end
        end
        if (have_px) begin
            px.end_of_word = 1'b1;
            pending_pixels.push_back(px);
        end
        src_word++;
        if (src_word >= LINE_WORDS) begin
            src_word = 0;
            src_line++;
            if (src_line >= DISPLAY_LINES) begin
                src_line = 0;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected %h, got %h", field, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_pixel want;
        if (!i_rst_n) begin
            phosphor_argb = 32'hFFFF_FFFF;
            cursor_argb = 32'hFFFF_FFFF;
            cursor_left = 0;
            cursor_top = 0;
            shift_x = 0;
            shift_y = 0;
            win_w = 1024;
            win_h = 1024;
            src_line = 0;
            src_word = 0;
            foreach (cursor_rows[r]) begin
                cursor_rows[r] = '0;
            end
            pending_pixels.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_pixels.size() == 0) begin
                    $error("pixel item with nothing expected: %h", m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    check_field("pixel_color", want.argb, m_axis_tdata[31:0]);
                    check_field("dest_x", 32'(want.x), 32'(m_axis_tdata[43:32]));
                    check_field("dest_y", 32'(want.y), 32'(m_axis_tdata[55:44]));
                    check_field("last", 32'(want.end_of_word), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == ACT_CURSOR_LOAD) begin
                    cursor_rows[s_axis_tdata[3:0]] = s_axis_tdata[19:4];
                end else begin
                    render_word(s_axis_tdata[19:4]);
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_PHOSPHOR_COLOR: phosphor_argb = i_cfg_data;
                    REG_CURSOR_COLOR:   cursor_argb = i_cfg_data;
                    REG_CURSOR_COL:     cursor_left = int'(i_cfg_data[9:0]);
                    REG_CURSOR_ROW:     cursor_top = int'(i_cfg_data[9:0]);
                    REG_ORIGIN_X:       shift_x = int'($signed(i_cfg_data[11:0]));
                    REG_ORIGIN_Y:       shift_y = int'($signed(i_cfg_data[11:0]));
                    REG_WINDOW_WIDTH:   win_w = int'(i_cfg_data[12:0]);
                    REG_WINDOW_HEIGHT:  win_h = int'(i_cfg_data[12:0]);
                    default: begin
                    end
                endcase
            end
        end
        o_pending = pending_pixels.size();
    end

endmodule

### verif/tb_top.sv
// testbench top: clock, reset, config and item stimulus, pixel back-pressure, verdict
`timescale 1ns / 1ps

module tb_top;
    import mbdc_pkg::*;

    localparam int CYCLE_LIMIT  = 600_000;
    localparam int IDLE_PCT     = 27;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 55;
    localparam int PHASES       = 6;
    localparam int EXTREME_PCT  = 15;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          words_sent = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;

    logic [31:0] cfg_phosphor;
    logic [31:0] cfg_cursor;
    int          cfg_col;
    int          cfg_row;
    int          cfg_ox;
    int          cfg_oy;
    int          cfg_w;
    int          cfg_h;

    mono_bitmap_display_cursor_overlay_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    mbdc_pixel_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // pixel side: random stalls, plus one long hold-off so the block backs up
    initial begin : pixel_ready
        int stall_count;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                for (stall_count = 0; stall_count < HOLD_CYCLES; stall_count++) begin
                    @(negedge i_clk);
                end
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_item(input t_action act, input logic [3:0] row,
                             input logic [15:0] bits);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {4'h0, bits, row};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (act == ACT_DISPLAY) begin
            words_sent++;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        // a word with no visible pixel may still be in flight
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
    endtask

    task automatic apply_config();
        wait_drained();
        write_reg(REG_PHOSPHOR_COLOR, cfg_phosphor);
        write_reg(REG_CURSOR_COLOR, cfg_cursor);
        write_reg(REG_CURSOR_COL, {22'b0, 10'(cfg_col)});
        write_reg(REG_CURSOR_ROW, {22'b0, 10'(cfg_row)});
        write_reg(REG_ORIGIN_X, {20'b0, 12'(cfg_ox)});
        write_reg(REG_ORIGIN_Y, {20'b0, 12'(cfg_oy)});
        write_reg(REG_WINDOW_WIDTH, {19'b0, 13'(cfg_w)});
        write_reg(REG_WINDOW_HEIGHT, {19'b0, 13'(cfg_h)});
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly a window that shows the current lines with the cursor nearby, sometimes extremes
    task automatic random_config();
        int line;
        line = (words_sent / LINE_WORDS) % DISPLAY_LINES;
        cfg_phosphor = $urandom;
        cfg_cursor = $urandom;
        if ($urandom_range(0, 99) < EXTREME_PCT) begin
            cfg_col = $urandom_range(0, 1) ? LINE_PIXELS : 0;
        end else begin
            cfg_col = $urandom_range(0, LINE_PIXELS);
        end
        if ($urandom_range(0, 99) < EXTREME_PCT) begin
            cfg_row = $urandom_range(0, 1) ? DISPLAY_LINES : 0;
        end else begin
            cfg_row = line - int'($urandom_range(0, 12));
            if (cfg_row < 0) begin
                cfg_row = 0;
            end
        end
        if ($urandom_range(0, 99) < EXTREME_PCT) begin
            cfg_ox = $urandom_range(0, 1) ? 2047 : -2048;
        end else begin
            cfg_ox = int'($urandom_range(0, 80)) - 40;
        end
        if ($urandom_range(0, 99) < EXTREME_PCT) begin
            cfg_oy = $urandom_range(0, 1) ? 2047 : -2048;
        end else begin
            cfg_oy = int'($urandom_range(0, 8)) - 4;
        end
        if ($urandom_range(0, 99) < EXTREME_PCT) begin
            cfg_w = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 1) ? 1 : 4096;
        end else begin
            cfg_w = $urandom_range(300, 4096);
        end
        if ($urandom_range(0, 99) < EXTREME_PCT) begin
            cfg_h = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 1) ? 1 : 4096;
        end else begin
            cfg_h = $urandom_range(16, 4096);
        end
        apply_config();
    endtask

    task automatic random_items(input int count);
        t_action     act;
        logic [15:0] bits;
        repeat (count) begin
            act = ($urandom_range(0, 99) < 20) ? ACT_CURSOR_LOAD : ACT_DISPLAY;
            bits = ($urandom_range(0, 9) == 0) ? 16'h0000 :
                   ($urandom_range(0, 8) == 0) ? 16'hFFFF : 16'($urandom);
            send_item(act, 4'($urandom), bits);
        end
    endtask

    initial begin : stimulus
        cfg_phosphor = 32'hFFFF_FFFF;
        cfg_cursor = 32'hFFFF_FFFF;
        cfg_col = 0;
        cfg_row = 0;
        cfg_ox = 0;
        cfg_oy = 0;
        cfg_w = 1024;
        cfg_h = 1024;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, cursor store still empty over the first word
        send_item(ACT_DISPLAY, 4'hF, 16'hFFFF);
        send_item(ACT_DISPLAY, 4'h0, 16'h0000);
        send_item(ACT_DISPLAY, 4'h5, 16'h8001);
        send_item(ACT_CURSOR_LOAD, 4'h0, 16'hFFFF);
        send_item(ACT_CURSOR_LOAD, 4'h1, 16'h8001);
        send_item(ACT_CURSOR_LOAD, 4'hF, 16'h5A5A);

        // cursor straddling two words, color channels that truncate when dimmed
        cfg_phosphor = 32'h12FF_8107;
        cfg_cursor = 32'h0000_0000;
        cfg_col = 56;
        apply_config();
        send_item(ACT_DISPLAY, 4'hA, 16'hFFFF);
        send_item(ACT_DISPLAY, 4'h3, 16'h0000);

        // origin far out on either side drops the whole word
        cfg_ox = -2048;
        apply_config();
        send_item(ACT_DISPLAY, 4'h0, 16'hF0F0);
        cfg_ox = 2047;
        apply_config();
        send_item(ACT_DISPLAY, 4'h0, 16'h0F0F);

        // window edges cutting through a word, then a zero-width window
        cfg_ox = -((words_sent % LINE_WORDS) * 16) - 8;
        cfg_w = 4096;
        apply_config();
        send_item(ACT_DISPLAY, 4'h6, 16'hC3C3);
        cfg_ox = 0;
        cfg_w = (words_sent % LINE_WORDS) * 16 + 5;
        apply_config();
        send_item(ACT_DISPLAY, 4'h9, 16'h3C3C);
        cfg_w = 0;
        apply_config();
        send_item(ACT_DISPLAY, 4'h0, 16'hFFFF);

        cfg_w = 4096;
        cfg_oy = -2048;
        apply_config();
        send_item(ACT_DISPLAY, 4'h0, 16'hFFFF);
        cfg_oy = 2047;
        apply_config();
        send_item(ACT_DISPLAY, 4'h0, 16'hAAAA);
        cfg_h = 4096;
        apply_config();
        send_item(ACT_DISPLAY, 4'h0, 16'h5555);
        cfg_h = 0;
        apply_config();
        send_item(ACT_DISPLAY, 4'h0, 16'hFFFF);
        cfg_oy = 0;
        cfg_h = 1;
        apply_config();
        send_item(ACT_DISPLAY, 4'hC, 16'h1234);

        for (int phase = 0; phase < PHASES; phase++) begin
            random_config();
            no_idle = (phase == 2);
            if (phase == 0) begin
                hold_req = 1'b1;
            end
            random_items(PHASE_ITEMS);
        end
        no_idle = 1'b0;

        // cursor hanging off the right end of the line, across a line change
        cfg_phosphor = $urandom;
        cfg_cursor = $urandom;
        cfg_col = LINE_PIXELS - 6;
        cfg_row = (words_sent / LINE_WORDS) % DISPLAY_LINES;
        cfg_ox = int'($urandom_range(0, 20)) - 10;
        cfg_oy = 0;
        cfg_w = 4096;
        cfg_h = 4096;
        apply_config();
        for (int r = 0; r < CURSOR_SIZE; r++) begin
            send_item(ACT_CURSOR_LOAD, 4'(r), 16'($urandom));
        end
        repeat (2 * LINE_WORDS) begin
            send_item(ACT_DISPLAY, 4'($urandom), 16'($urandom));
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/mbdc_pkg.sv
sv/mbdc_emitter.sv
sv/mono_bitmap_display_cursor_overlay_core.sv
sv/mbdc_checker.sv
verif/mbdc_pixel_checker.sv
verif/tb_top.sv
